/* rtl/priority_ready_queue_scheduler_assert.svh */
// Assertion macros shared by the scheduler modules.
`ifndef PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH
`define PRIORITY_READY_QUEUE_SCHEDULER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define PRQS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define PRQS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/prqs_pkg.sv */
// ---------------------------------------------------------------------------
// prqs_pkg
// Types, sizes and codes shared by the priority ready queue scheduler.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package prqs_pkg;

  localparam int NumLevels    = 8;
  localparam int QueueDepth   = 16;
  localparam int NumTaskSlots = 64;
  localparam int MaxCores     = 16;

  localparam int LevelW = $clog2(NumLevels);
  localparam int PosW   = $clog2(QueueDepth);
  localparam int FillW  = $clog2(QueueDepth + 1);
  localparam int TaskW  = 6;
  localparam int SlotW  = $clog2(NumTaskSlots);
  localparam int CoreW  = $clog2(MaxCores);
  localparam int CntW   = $clog2(MaxCores + 1);
  localparam int LoadW  = 16;
  localparam int QAddrW = LevelW + PosW;

  typedef enum logic [1:0] {
    FUNC_CREATE   = 2'd0,
    FUNC_REMOVE   = 2'd1,
    FUNC_SCHEDULE = 2'd2,
    FUNC_SET      = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    RS_WAITING  = 2'd0,
    RS_RUNNING  = 2'd1,
    RS_BLOCKED  = 2'd2,
    RS_FINISHED = 2'd3
  } run_state_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOTFOUND = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0] func;
    logic [5:0] task_id;
    logic [2:0] priority_req;
    logic [1:0] new_state;
  } in_item_t;

  typedef struct packed {
    logic [5:0] chosen_task;
    logic [3:0] chosen_core;
    logic       found;
    logic [5:0] previous_task;
    logic       switched;
    logic [1:0] status;
  } out_item_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic capture;     // latch the input item
    logic core_clr;    // restart core search
    logic core_step;   // examine next core
    logic tbl_rd;      // read task table for task_id
    logic create_wr;   // write table, queue, load for create
    logic rm_init;     // never asserted; tbl_rd sets the level for remove
    logic q_rd;        // issue queue read at scan pointer
    logic rm_cmp;      // compare queue data with task_id
    logic sh_wr;       // shift queue entry down one place
    logic rm_done;     // decrement fill
    logic sc_init;     // start schedule scan
    logic sc_eval;     // check state of queued task
    logic sc_next;     // advance schedule scan
    logic sc_commit;   // perform switch
    logic set_wr;      // write run state
    logic emit;        // present result
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic core_last;   // core search finished
    logic id_ok;
    logic rm_hit;
    logic rm_end;      // scan pointer reached fill
    logic sh_end;      // shift finished
    logic sc_hit;
    logic sc_pos_end;  // level exhausted
    logic sc_lvl_end;  // all levels exhausted
    logic [1:0] func;
  } stat_t;

endpackage

/* rtl/prqs_ctrl.sv */
// ---------------------------------------------------------------------------
// prqs_ctrl
// Sequencer that steps the datapath through one operation at a time.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "priority_ready_queue_scheduler_assert.svh"
module prqs_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  output prqs_pkg::cmd_t cmd_o,
  input  prqs_pkg::stat_t stat_i
);
  import prqs_pkg::*;

  typedef enum logic [12:0] {
    S_IDLE    = 13'h0001,
    S_CORE    = 13'h0002,
    S_CWR     = 13'h0004,
    S_TBL     = 13'h0008,
    S_RMRD    = 13'h0010,
    S_RMCMP   = 13'h0020,
    S_SHRD    = 13'h0040,
    S_SHWR    = 13'h0080,
    S_SCRD    = 13'h0100,
    S_SCTBL   = 13'h0200,
    S_SCEVAL  = 13'h0400,
    S_SCCOMMIT = 13'h0800,
    S_DONE    = 13'h1000
  } state_e;

  state_e state_q, state_d;

  assign busy = (state_q != S_IDLE);

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.capture = 1'b1;
          cmd_o.core_clr = 1'b1;
          state_d = S_TBL;
        end
      end
      S_TBL: begin
        // Task table read for the latched task_id; schedule starts its scan, set writes the state.
        cmd_o.tbl_rd = 1'b1;
        case (func_e'(stat_i.func))
          FUNC_CREATE:   state_d = stat_i.id_ok ? S_CORE : S_DONE;
          FUNC_REMOVE:   state_d = stat_i.id_ok ? S_RMRD : S_DONE;
          FUNC_SCHEDULE: begin
            cmd_o.sc_init = 1'b1;
            state_d = S_SCRD;
          end
          default: begin
            cmd_o.set_wr = 1'b1;
            state_d = S_DONE;
          end
        endcase
      end
      S_CORE: begin
        cmd_o.core_step = 1'b1;
        if (stat_i.core_last) state_d = S_CWR;
      end
      S_CWR: begin
        cmd_o.create_wr = 1'b1;
        state_d = S_DONE;
      end
      S_RMRD: begin
        // The first visit follows the table read, which set up the level; later visits follow a compare miss.
        cmd_o.rm_init = 1'b0;
        if (stat_i.rm_end) begin
          state_d = S_DONE;
        end else begin
          cmd_o.q_rd = 1'b1;
          state_d = S_RMCMP;
        end
      end
      S_RMCMP: begin
        cmd_o.rm_cmp = 1'b1;
        state_d = stat_i.rm_hit ? S_SHRD : S_RMRD;
      end
      S_SHRD: begin
        if (stat_i.sh_end) begin
          cmd_o.rm_done = 1'b1;
          state_d = S_DONE;
        end else begin
          cmd_o.q_rd = 1'b1;
          state_d = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd_o.sh_wr = 1'b1;
        state_d = S_SHRD;
      end
      S_SCRD: begin
        if (stat_i.sc_lvl_end) begin
          state_d = S_DONE;
        end else if (stat_i.sc_pos_end) begin
          cmd_o.sc_next = 1'b1;
        end else begin
          cmd_o.q_rd = 1'b1;
          state_d = S_SCTBL;
        end
      end
      S_SCTBL: begin
        cmd_o.sc_eval = 1'b1;
        state_d = S_SCEVAL;
      end
      S_SCEVAL: begin
        if (stat_i.sc_hit) begin
          state_d = S_SCCOMMIT;
        end else begin
          cmd_o.sc_next = 1'b1;
          state_d = S_SCRD;
        end
      end
      S_SCCOMMIT: begin
        cmd_o.sc_commit = 1'b1;
        state_d = S_DONE;
      end
      S_DONE: begin
        cmd_o.emit = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `PRQS_ASSERT_IMP(a_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q), "state not one-hot")
  `PRQS_ASSERT_NEXT(a_emit_idle, clk_i, rst_ni, cmd_o.emit, state_q == S_IDLE,
                    "emit not followed by idle")
  `PRQS_ASSERT_NEXT(a_start_busy, clk_i, rst_ni, start && !busy, busy,
                    "accepted item did not raise busy")

endmodule

/* rtl/prqs_datapath.sv */
// ---------------------------------------------------------------------------
// prqs_datapath
// Task table, ready queue memory, load counters and scan pointers.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "priority_ready_queue_scheduler_assert.svh"
module prqs_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  prqs_pkg::in_item_t  item_i,
  input  logic                cfg_we_i,
  input  logic [4:0]          cfg_wdata_i,
  input  prqs_pkg::cmd_t      cmd_i,
  output prqs_pkg::stat_t     stat_o,
  output logic                res_valid_o,
  output prqs_pkg::out_item_t res_o
);
  import prqs_pkg::*;

  // Task table and ready queue memories.
  logic [LevelW-1:0] lvl_mem [NumTaskSlots];
  logic [CoreW-1:0]  core_mem [NumTaskSlots];
  logic [1:0]        rs_mem [NumTaskSlots];
  logic [TaskW-1:0]  q_mem [NumLevels*QueueDepth];

  in_item_t          item_q;
  logic [4:0]        core_cnt_q;
  logic [FillW-1:0]  fill_q [NumLevels];
  logic [LoadW-1:0]  load_q [MaxCores];
  logic [TaskW-1:0]  cur_q;
  logic              cur_v_q;

  logic [CntW-1:0]   ci_q;
  logic [CoreW-1:0]  best_q;
  logic              zero_found_q;
  logic [LevelW-1:0] lvl_q;
  logic [FillW-1:0]  pos_q;
  logic              lvl_end_q;
  logic [TaskW-1:0]  qd_q;
  logic [CoreW-1:0]  tc_q;
  logic [1:0]        rs_q;
  logic              hit_q;
  logic              full_q;
  logic              res_v_q;
  out_item_t         res_q;

  logic [CntW-1:0]   ncores;
  logic              id_ok;
  logic [QAddrW-1:0] qaddr;
  logic [LevelW-1:0] plevel;
  logic [CoreW-1:0]  ci_idx;

  // Blocking of the switched-out task happens on the cycle after commit
  // using the held previous id.
  logic              blk_q;
  logic [TaskW-1:0]  blk_id_q;

  // Effective core count clamp.
  always_comb begin
    if (core_cnt_q == 5'd0) ncores = CntW'(1);
    else if (32'(core_cnt_q) > MaxCores) ncores = CntW'(MaxCores);
    else ncores = CntW'(core_cnt_q);
  end

  assign id_ok  = 32'(item_q.task_id) < NumTaskSlots;
  assign ci_idx = ci_q[CoreW-1:0];
  assign qaddr  = {lvl_q, pos_q[PosW-1:0]};
  assign plevel = (32'(item_q.priority_req) >= NumLevels) ? LevelW'(NumLevels - 1)
                : LevelW'(item_q.priority_req);

  assign stat_o.core_last  = zero_found_q || (ci_q >= ncores);
  assign stat_o.id_ok      = id_ok;
  assign stat_o.rm_hit     = (qd_q == item_q.task_id);
  assign stat_o.rm_end     = pos_q >= fill_q[lvl_q];
  assign stat_o.sh_end     = pos_q >= fill_q[lvl_q];
  assign stat_o.sc_hit     = (rs_q != RS_RUNNING) && (rs_q != RS_FINISHED);
  assign stat_o.sc_pos_end = pos_q >= fill_q[lvl_q];
  assign stat_o.sc_lvl_end = lvl_end_q;
  assign stat_o.func       = item_q.func;

  // Configuration register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      core_cnt_q <= 5'd1;
    end else if (cfg_we_i) begin
      core_cnt_q <= cfg_wdata_i;
    end
  end

  // Memories: table and queue writes, registered reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    if (cmd_i.create_wr) begin
      lvl_mem[item_q.task_id[SlotW-1:0]]  <= plevel;
      core_mem[item_q.task_id[SlotW-1:0]] <= best_q;
      if (32'(fill_q[plevel]) < QueueDepth) begin
        q_mem[{plevel, fill_q[plevel][PosW-1:0]}] <= item_q.task_id;
      end
    end
    if (cmd_i.q_rd) begin
      qd_q <= q_mem[qaddr];
    end
    if (cmd_i.sh_wr) begin
      q_mem[{lvl_q, PosW'(pos_q - FillW'(1))}] <= qd_q;
    end
    if (cmd_i.sc_eval) begin
      rs_q <= rs_mem[qd_q[SlotW-1:0]];
      tc_q <= core_mem[qd_q[SlotW-1:0]];
    end
  end

  // Run state memory: one write port, muxed by operation.
  always_ff @(posedge clk_i) begin
    if (cmd_i.create_wr) begin
      rs_mem[item_q.task_id[SlotW-1:0]] <= RS_WAITING;
    end else if (cmd_i.set_wr && id_ok) begin
      rs_mem[item_q.task_id[SlotW-1:0]] <= item_q.new_state;
    end else if (cmd_i.sc_commit) begin
      rs_mem[qd_q[SlotW-1:0]] <= RS_RUNNING;
    end else if (blk_q) begin
      rs_mem[blk_id_q[SlotW-1:0]] <= RS_BLOCKED;
    end
  end

  // Switch-out flag and the id it applies to.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_q <= 1'b0;
    end else begin
      blk_q <= cmd_i.sc_commit && cur_v_q && (cur_q != qd_q);
    end
  end
  always_ff @(posedge clk_i) begin
    if (cmd_i.sc_commit) blk_id_q <= cur_q;
  end

  // Control registers: fills, loads, scan pointers and current task.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumLevels; i++) fill_q[i] <= '0;
      for (int i = 0; i < MaxCores; i++) load_q[i] <= '0;
      cur_q <= '0;
      cur_v_q <= 1'b0;
      ci_q <= '0;
      best_q <= '0;
      zero_found_q <= 1'b0;
      lvl_q <= '0;
      pos_q <= '0;
      lvl_end_q <= 1'b0;
      hit_q <= 1'b0;
      full_q <= 1'b0;
    end else begin
      if (cmd_i.core_clr) begin
        ci_q <= '0;
        best_q <= '0;
        zero_found_q <= 1'b0;
      end
      if (cmd_i.core_step && !stat_o.core_last) begin
        if (load_q[ci_idx] == '0) begin
          zero_found_q <= 1'b1;
          best_q <= ci_idx;
        end else if (load_q[ci_idx] < load_q[best_q]) begin
          best_q <= ci_idx;
        end
        ci_q <= ci_q + CntW'(1);
      end
      if (cmd_i.create_wr) begin
        // The level is full if it had no room before this create.
        full_q <= !(32'(fill_q[plevel]) < QueueDepth);
        if (32'(fill_q[plevel]) < QueueDepth) fill_q[plevel] <= fill_q[plevel] + FillW'(1);
        if (load_q[best_q] != '1) load_q[best_q] <= load_q[best_q] + LoadW'(1);
      end
      if (cmd_i.tbl_rd) begin
        hit_q <= 1'b0;
        pos_q <= '0;
        lvl_q <= lvl_mem[item_q.task_id[SlotW-1:0]];
      end
      if (cmd_i.rm_cmp) begin
        hit_q <= (qd_q == item_q.task_id);
        pos_q <= pos_q + FillW'(1);
      end
      if (cmd_i.sh_wr) begin
        pos_q <= pos_q + FillW'(1);
      end
      if (cmd_i.rm_done) begin
        fill_q[lvl_q] <= fill_q[lvl_q] - FillW'(1);
      end
      if (cmd_i.sc_init) begin
        lvl_q <= LevelW'(NumLevels - 1);
        pos_q <= '0;
        lvl_end_q <= 1'b0;
      end
      if (cmd_i.sc_next) begin
        if (stat_o.sc_pos_end || !cmd_i.sc_eval) begin
          if (stat_o.sc_pos_end) begin
            if (lvl_q == '0) lvl_end_q <= 1'b1;
            else lvl_q <= lvl_q - LevelW'(1);
            pos_q <= '0;
          end else begin
            pos_q <= pos_q + FillW'(1);
          end
        end
      end
      if (cmd_i.sc_commit) begin
        cur_q <= qd_q;
        cur_v_q <= 1'b1;
      end
    end
  end

  // Result assembly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_v_q <= 1'b0;
    end else begin
      res_v_q <= cmd_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q <= '0;
      res_q.chosen_task <= item_q.task_id;
      case (func_e'(item_q.func))
        FUNC_CREATE: begin
          if (!id_ok) begin
            res_q.status <= STAT_NOTFOUND;
          end else begin
            res_q.chosen_core <= best_q;
            res_q.status <= full_q ? STAT_FULL : STAT_OK;
          end
        end
        FUNC_REMOVE: begin
          res_q.found  <= hit_q;
          res_q.status <= hit_q ? STAT_OK : STAT_NOTFOUND;
        end
        FUNC_SCHEDULE: begin
          if (lvl_end_q) begin
            res_q.chosen_task <= '0;
            res_q.status <= STAT_NOTFOUND;
          end else begin
            res_q.chosen_task   <= qd_q;
            res_q.chosen_core   <= tc_q;
            res_q.found         <= 1'b1;
            res_q.previous_task <= blk_q ? blk_id_q : '0;
            res_q.switched      <= blk_q;
          end
        end
        default: begin
          res_q.status <= id_ok ? STAT_OK : STAT_NOTFOUND;
        end
      endcase
    end
  end

  assign res_valid_o = res_v_q;
  assign res_o = res_q;

  `PRQS_ASSERT_IMP(a_fill_max, clk_i, rst_ni, 1'b1, 32'(fill_q[lvl_q]) <= QueueDepth,
                   "queue fill above depth")
  `PRQS_ASSERT_NEXT(a_commit_cur, clk_i, rst_ni, cmd_i.sc_commit, cur_v_q,
                    "commit did not set current task")
  `PRQS_ASSERT_IMP(a_rm_nonempty, clk_i, rst_ni, cmd_i.rm_done, fill_q[lvl_q] != '0,
                   "remove from empty queue")

endmodule

/* rtl/priority_ready_queue_scheduler.sv */
// ---------------------------------------------------------------------------
// priority_ready_queue_scheduler
// Fixed-priority task scheduler with per-level ready queues.
// ---------------------------------------------------------------------------
// Usage: drive item_i and raise start while busy is low; the item is taken at
// that edge and busy stays high until the result is out. The result appears
// on result_o for exactly one cycle with result_valid_o high and cannot be
// stalled. The core_count register must be written through cfg_we_i and
// cfg_wdata_i only while the block is idle; the block does not enforce it.
// Create scans the core loads serially; set writes the run state in the table
// read state; remove scans its level and then shifts the later entries down;
// schedule scans the levels from the highest down, entry by entry, and stops at
// the first task that is neither running nor finished. The ready queue memory
// is single-ported. One item is in flight at a time.
// Reset clears the queue fills, the core loads, the current task and sets
// core_count to one; the task table and queue contents are not cleared.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module priority_ready_queue_scheduler (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  prqs_pkg::in_item_t  item_i,
  input  logic                cfg_we_i,
  input  logic [4:0]          cfg_wdata_i,
  output logic                result_valid_o,
  output prqs_pkg::out_item_t result_o
);
  import prqs_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  prqs_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .stat_i (stat)
  );

  prqs_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

endmodule

/* verif/priority_ready_queue_scheduler_tb.sv */
// ---------------------------------------------------------------------------
// priority_ready_queue_scheduler_tb
// Self-checking testbench for the priority ready queue scheduler. A cycle-free
// predictor of the task table, ready queues and core loads computes each
// expected result item. A checker compares every result item with the oldest
// expectation, field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module priority_ready_queue_scheduler_tb;
  import prqs_pkg::*;

  localparam int WatchdogLimit = 4000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  item_i = '0;
  logic      cfg_we_i = 1'b0;
  logic [4:0] cfg_wdata_i = '0;
  logic      result_valid_o;
  out_item_t result_o;

  priority_ready_queue_scheduler dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

  always #4 clk_i = ~clk_i;

  // Predicted scheduler state.
  logic [2:0]  lvl_of   [NumTaskSlots];
  logic [3:0]  core_of  [NumTaskSlots];
  run_state_e  state_of [NumTaskSlots];
  logic [5:0]  ready_q  [NumLevels][QueueDepth];
  int unsigned fill     [NumLevels];
  logic [15:0] load     [MaxCores];
  logic [5:0]  cur_id;
  logic        cur_live;
  logic [4:0]  cores_cfg;
  bit          created  [NumTaskSlots];

  out_item_t   pending_results[$];
  int unsigned errors = 0;
  int unsigned n_items = 0;
  int unsigned n_results = 0;
  int unsigned n_cfg = 0;
  bit          idle_on = 1'b1;
  int unsigned quiet = 0;

  // Computes the result of one item and advances the predicted state.
  function automatic out_item_t sched_step(in_item_t it);
    out_item_t r;
    int unsigned n, best, lv, i, j;
    bit got;
    logic [5:0] pick, t;
    r = '0;
    r.chosen_task = it.task_id;
    r.status = STAT_OK;
    case (func_e'(it.func))
      FUNC_CREATE: begin
        n = (cores_cfg < 1) ? 1 : ((cores_cfg > MaxCores) ? MaxCores : cores_cfg);
        best = 0;
        for (i = 0; i < n; i++) begin
          if (load[i] == 0) begin
            best = i;
            break;
          end
          if (load[i] < load[best]) best = i;
        end
        lv = it.priority_req;
        lvl_of[it.task_id] = 3'(lv);
        core_of[it.task_id] = 4'(best);
        state_of[it.task_id] = RS_WAITING;
        created[it.task_id] = 1'b1;
        if (fill[lv] < QueueDepth) begin
          ready_q[lv][fill[lv]] = it.task_id;
          fill[lv]++;
        end else begin
          r.status = STAT_FULL;
        end
        if (load[best] != 16'hFFFF) load[best]++;
        r.chosen_core = 4'(best);
      end
      FUNC_REMOVE: begin
        r.status = STAT_NOTFOUND;
        lv = lvl_of[it.task_id];
        for (i = 0; i < fill[lv]; i++) begin
          if (ready_q[lv][i] == it.task_id) begin
            for (j = i; j + 1 < fill[lv]; j++) ready_q[lv][j] = ready_q[lv][j + 1];
            fill[lv]--;
            r.found = 1'b1;
            r.status = STAT_OK;
            break;
          end
        end
      end
      FUNC_SCHEDULE: begin
        got = 1'b0;
        pick = '0;
        for (int l = NumLevels - 1; l >= 0 && !got; l--) begin
          for (i = 0; i < fill[l]; i++) begin
            t = ready_q[l][i];
            if (state_of[t] != RS_RUNNING && state_of[t] != RS_FINISHED) begin
              pick = t;
              got = 1'b1;
              break;
            end
          end
        end
        if (!got) begin
          r.chosen_task = '0;
          r.status = STAT_NOTFOUND;
        end else begin
          if (cur_live && cur_id != pick) begin
            state_of[cur_id] = RS_BLOCKED;
            r.previous_task = cur_id;
            r.switched = 1'b1;
          end
          cur_id = pick;
          cur_live = 1'b1;
          state_of[pick] = RS_RUNNING;
          r.chosen_task = pick;
          r.chosen_core = core_of[pick];
          r.found = 1'b1;
        end
      end
      default: begin
        state_of[it.task_id] = run_state_e'(it.new_state);
      end
    endcase
    return r;
  endfunction

  // Sends one item; it is taken at the edge after the falling edge where busy is low.
  task automatic send_item(func_e f, logic [5:0] id, logic [2:0] prio, run_state_e st);
    in_item_t it;
    it.func = f;
    it.task_id = id;
    it.priority_req = prio;
    it.new_state = st;
    if (idle_on && $urandom_range(0, 3) == 0) repeat ($urandom_range(1, 6)) @(negedge clk_i);
    @(negedge clk_i);
    while (busy) @(negedge clk_i);
    start = 1'b1;
    item_i = it;
    @(posedge clk_i);
    pending_results.push_back(sched_step(it));
    n_items++;
    @(negedge clk_i);
    start = 1'b0;
  endtask

  // Waits until every expected result has arrived and the block has settled.
  task automatic wait_drained();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Writes the core count register while the block is idle.
  task automatic write_core_count(logic [4:0] val);
    wait_drained();
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cores_cfg = val;
    n_cfg++;
  endtask

  // Result checker: every result item must match the oldest expectation.
  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni && result_valid_o) begin
      n_results++;
      if (pending_results.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result item %p", result_o);
      end else begin
        exp_r = pending_results.pop_front();
        if (result_o.chosen_task !== exp_r.chosen_task ||
            result_o.chosen_core !== exp_r.chosen_core ||
            result_o.found !== exp_r.found ||
            result_o.previous_task !== exp_r.previous_task ||
            result_o.switched !== exp_r.switched ||
            result_o.status !== exp_r.status) begin
          errors++;
          if (errors <= 10) $display("mismatch: expected %p, actual %p", exp_r, result_o);
        end
      end
    end
  end

  // Watchdog on cycles in which no item moves in either direction.
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || result_valid_o || cfg_we_i) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= WatchdogLimit) begin
        $display("watchdog expired with %0d results outstanding", pending_results.size());
        $display("[priority_ready_queue_scheduler] ERROR");
        $finish;
      end
    end
  end

  // Empty queue, duplicates, skipping running and finished tasks, switching,
  // rescheduling the current task and removal down to empty queues.
  task automatic test_directed();
    write_core_count(5'd1);
    send_item(FUNC_SCHEDULE, 6'd0, 3'd0, RS_WAITING);
    send_item(FUNC_CREATE, 6'd5, 3'd3, RS_WAITING);
    send_item(FUNC_CREATE, 6'd63, 3'd7, RS_WAITING);
    send_item(FUNC_CREATE, 6'd0, 3'd0, RS_WAITING);
    send_item(FUNC_CREATE, 6'd5, 3'd3, RS_WAITING);
    send_item(FUNC_SCHEDULE, 6'd0, 3'd0, RS_WAITING);
    send_item(FUNC_SCHEDULE, 6'd0, 3'd0, RS_WAITING);
    send_item(FUNC_SET, 6'd63, 3'd0, RS_FINISHED);
    send_item(FUNC_SCHEDULE, 6'd0, 3'd0, RS_WAITING);
    send_item(FUNC_SET, 6'd5, 3'd0, RS_WAITING);
    send_item(FUNC_SCHEDULE, 6'd0, 3'd0, RS_WAITING);
    send_item(FUNC_SET, 6'd5, 3'd0, RS_WAITING);
    send_item(FUNC_SCHEDULE, 6'd0, 3'd0, RS_WAITING);
    send_item(FUNC_SET, 6'd0, 3'd0, RS_BLOCKED);
    send_item(FUNC_SET, 6'd2, 3'd0, RS_RUNNING);
    send_item(FUNC_REMOVE, 6'd5, 3'd0, RS_WAITING);
    send_item(FUNC_REMOVE, 6'd5, 3'd0, RS_WAITING);
    send_item(FUNC_REMOVE, 6'd5, 3'd0, RS_WAITING);
    send_item(FUNC_REMOVE, 6'd63, 3'd0, RS_WAITING);
    send_item(FUNC_REMOVE, 6'd0, 3'd0, RS_WAITING);
    send_item(FUNC_SCHEDULE, 6'd0, 3'd0, RS_WAITING);
  endtask

  // Least-loaded core choice over a few cores, then a level filled past its depth.
  task automatic test_core_choice_and_full_queue();
    write_core_count(5'd4);
    for (int i = 0; i < 7; i++) send_item(FUNC_CREATE, 6'(8 + i), 3'd1, RS_WAITING);
    for (int i = 0; i < QueueDepth + 1; i++) send_item(FUNC_CREATE, 6'(20 + i), 3'd6, RS_WAITING);
    send_item(FUNC_SCHEDULE, 6'd0, 3'd0, RS_WAITING);
  endtask

  // Random mix of operations; removes only name tasks already created.
  task automatic test_random(int unsigned count);
    int unsigned r;
    logic [5:0] id;
    for (int unsigned k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      id = 6'($urandom_range(0, NumTaskSlots - 1));
      if (r >= 35 && r < 60) begin
        for (int tries = 0; tries < 64 && !created[id]; tries++) id = id + 6'd1;
        if (created[id]) send_item(FUNC_REMOVE, id, 3'd0, RS_WAITING);
        else send_item(FUNC_CREATE, id, 3'($urandom), RS_WAITING);
      end else if (r < 35) begin
        send_item(FUNC_CREATE, id, 3'($urandom), RS_WAITING);
      end else if (r < 85) begin
        send_item(FUNC_SCHEDULE, 6'($urandom), 3'($urandom), run_state_e'(2'($urandom)));
      end else begin
        send_item(FUNC_SET, id, 3'($urandom), run_state_e'(2'($urandom)));
      end
    end
  endtask

  initial begin
    for (int i = 0; i < NumLevels; i++) fill[i] = 0;
    for (int i = 0; i < MaxCores; i++) load[i] = '0;
    for (int i = 0; i < NumTaskSlots; i++) created[i] = 1'b0;
    cur_id = '0;
    cur_live = 1'b0;
    cores_cfg = 5'd1;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_core_choice_and_full_queue();
    write_core_count(5'd16);
    test_random(300);
    write_core_count(5'd0);
    test_random(200);
    write_core_count(5'd31);
    test_random(300);
    write_core_count(5'($urandom_range(2, 15)));
    test_random(250);
    idle_on = 1'b0;
    write_core_count(5'($urandom_range(1, 16)));
    test_random(200);
    wait_drained();

    errors += pending_results.size();
    $display("Covered %0d items and %0d results over %0d core count settings,",
             n_items, n_results, n_cfg);
    $display("including duplicates, full levels, switches and empty schedules.");
    if (errors == 0) begin
      $display("[priority_ready_queue_scheduler] OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("[priority_ready_queue_scheduler] ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/prqs_pkg.sv
rtl/prqs_ctrl.sv
rtl/prqs_datapath.sv
rtl/priority_ready_queue_scheduler.sv
verif/priority_ready_queue_scheduler_tb.sv
